@@ design/spr_pkg.sv @@
// ----------------------------------------------------------------------------
// spr_pkg
// Shared constants and types of the slave recovery planner.
// ----------------------------------------------------------------------------
package spr_pkg;

  localparam int MAX_SLAVES = 64;
  localparam int SLAVE_W    = $clog2(MAX_SLAVES);
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);
  localparam int PADDR_W    = 4;
  localparam int REG_IDX_W  = PADDR_W - 2;
  localparam int TIME_W     = 64;
  localparam int SH_W       = 5;

  localparam logic [7:0] ST_MASK   = 8'h0F;
  localparam logic [7:0] ST_INIT   = 8'h01;
  localparam logic [7:0] ST_PREOP  = 8'h02;
  localparam logic [7:0] ST_SAFEOP = 8'h04;
  localparam logic [7:0] ST_OP     = 8'h08;
  localparam logic [7:0] ST_ERR    = 8'h10;
  localparam logic [SH_W-1:0] SHIFT_CAP = 5'd20;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_ACK   = 2'd1;
  localparam logic [1:0] ACT_OP    = 2'd2;
  localparam logic [1:0] ACT_RECFG = 2'd3;

  localparam logic [REG_IDX_W-1:0] REG_SLAVE_COUNT   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ATTEMPT_LIMIT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_BACKOFF_BASE  = 2'd2;

  typedef struct packed {
    logic [6:0]  slave_count;
    logic [7:0]  attempt_limit;
    logic [31:0] backoff_base;
  } cfg_t;

  typedef struct packed {
    logic               in_range;
    logic               clear_entry;
    logic               reach;
    logic               healthy;
    logic [1:0]         cand_act;
    logic [SLAVE_W-1:0] slave;
    logic [TIME_W-1:0]  now_ns;
  } job_t;

  typedef struct packed {
    logic [7:0]        attempts;
    logic              failed;
    logic              unhealthy;
    logic [TIME_W-1:0] next_try;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

@@ design/spr_in_if.sv @@
// ----------------------------------------------------------------------------
// spr_in_if
// Input channel of the slave recovery planner: one word per decision.
// ----------------------------------------------------------------------------
interface spr_in_if import spr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               mode;
  logic [SLAVE_W-1:0] slave;
  logic               reachable;
  logic               answered;
  logic [7:0]         status_byte;
  logic [TIME_W-1:0]  now_ns;

  modport source (output valid, mode, slave, reachable, answered, status_byte, now_ns,
                  input ready);
  modport sink (input valid, mode, slave, reachable, answered, status_byte, now_ns,
                output ready);
endinterface

@@ design/spr_out_if.sv @@
// ----------------------------------------------------------------------------
// spr_out_if
// Result channel of the slave recovery planner: one word per decision.
// ----------------------------------------------------------------------------
interface spr_out_if import spr_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic       recovered;
  logic       gave_up;
  logic [7:0] attempts_used;

  modport source (output valid, action, recovered, gave_up, attempts_used, input ready);
  modport sink (input valid, action, recovered, gave_up, attempts_used, output ready);
endinterface

@@ design/slave_recovery_planner.sv @@
// ----------------------------------------------------------------------------
// slave_recovery_planner
// Per-slave recovery planner with exponential backoff and attempt limit.
// ----------------------------------------------------------------------------
// Each input word decides one action for one slave and returns exactly one
// result word. The front end classifies the word and places it in a two-entry
// queue, so input is taken while the table is busy or a result waits. The back
// end handles one word in S_IDLE (table read), S_EVAL (evaluation with the
// 64-bit time compare) and S_UPD (backoff add, write-back and result load),
// since the 64-entry slave table sits in a RAM with registered read and each
// entry is read, updated and written back before the next word starts; no new
// word is taken until then, and S_UPD waits while an untaken result is held.
// The table needs no clearing pass after reset: each entry has a valid bit
// that reset clears, and an entry never written reads as all zero. The user
// must write configuration through the APB port only while no word is in
// flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module slave_recovery_planner import spr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  spr_in_if.sink             in_ch,
  spr_out_if.source          out_ch,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  cfg_t cfg;
  job_t job;
  logic job_valid;
  logic job_pop;

  spr_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  spr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_ch     (in_ch),
    .job       (job),
    .job_valid (job_valid),
    .job_pop   (job_pop)
  );

  spr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .job       (job),
    .job_valid (job_valid),
    .job_pop   (job_pop),
    .out_ch    (out_ch)
  );

endmodule

@@ design/spr_ram.sv @@
// ----------------------------------------------------------------------------
// spr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/spr_cfg.sv @@
// ----------------------------------------------------------------------------
// spr_cfg
// APB register file holding slave count, attempt limit and backoff base.
// ----------------------------------------------------------------------------
module spr_cfg import spr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready,
  output cfg_t               cfg
);

  cfg_t                 cfg_r;
  cfg_t                 cfg_nxt;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = cfg_paddr[PADDR_W-1:2];
  assign wr_en   = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_SLAVE_COUNT: begin
          cfg_nxt.slave_count = cfg_pwdata[6:0];
        end
        REG_ATTEMPT_LIMIT: begin
          cfg_nxt.attempt_limit = cfg_pwdata[7:0];
        end
        REG_BACKOFF_BASE: begin
          cfg_nxt.backoff_base = cfg_pwdata;
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SLAVE_COUNT:   cfg_prdata = {25'd0, cfg_r.slave_count};
      REG_ATTEMPT_LIMIT: cfg_prdata = {24'd0, cfg_r.attempt_limit};
      REG_BACKOFF_BASE:  cfg_prdata = cfg_r.backoff_base;
      default:           cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

endmodule

@@ design/spr_front.sv @@
// ----------------------------------------------------------------------------
// spr_front
// Accepts input words, classifies the slave condition and queues the job.
// ----------------------------------------------------------------------------
module spr_front import spr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  spr_in_if.sink      in_ch,
  output job_t        job,
  output logic        job_valid,
  input  logic        job_pop
);

  job_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;
  logic              push;
  logic              pop;
  job_t              cls;
  logic [7:0]        st;
  logic              err;

  assign st  = in_ch.status_byte & ST_MASK;
  assign err = (in_ch.status_byte & ST_ERR) != 8'h00;

  always_comb begin
    cls             = '0;
    cls.in_range    = {1'b0, in_ch.slave} < cfg.slave_count;
    cls.clear_entry = in_ch.mode;
    cls.reach       = in_ch.reachable;
    cls.healthy     = in_ch.answered && (st == ST_OP) && !err;
    cls.slave       = in_ch.slave;
    cls.now_ns      = in_ch.now_ns;
    if (!in_ch.answered || st == ST_INIT || st == ST_PREOP) begin
      cls.cand_act = ACT_RECFG;
    end else if (err) begin
      cls.cand_act = ACT_ACK;
    end else if (st == ST_SAFEOP) begin
      cls.cand_act = ACT_OP;
    end else begin
      cls.cand_act = ACT_NONE;
    end
  end

  assign in_ch.ready = count_r != QCNT_W'(QDEPTH);
  assign push        = in_ch.valid && in_ch.ready;
  assign job_valid   = count_r != '0;
  assign pop         = job_pop && job_valid;
  assign job         = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_q_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> count_r != '0 && count_r <= QCNT_W'(QDEPTH))
    else $error("Job queue count out of range after a push.");
`endif

endmodule

@@ design/spr_back.sv @@
// ----------------------------------------------------------------------------
// spr_back
// Reads the slave table entry, applies the recovery rules, writes the entry
// back and loads the result register.
// ----------------------------------------------------------------------------
module spr_back import spr_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  cfg_t   cfg,
  input  job_t   job,
  input  logic   job_valid,
  output logic   job_pop,
  spr_out_if.source out_ch
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EVAL = 3'b010,
    S_UPD  = 3'b100
  } back_state_t;

  back_state_t     state_r;
  back_state_t     state_nxt;
  job_t            job_r;
  logic [MAX_SLAVES-1:0] valid_r;
  logic [MAX_SLAVES-1:0] valid_nxt;

  logic            ram_we;
  logic            ram_re;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t          ent;
  entry_t          wr_ent;

  entry_t          ev_ent;
  logic [1:0]      ev_act;
  logic            ev_rec;
  logic            ev_gave;
  logic            ev_we;
  logic            ev_bump;
  logic [SH_W-1:0] ev_sh;

  entry_t          new_ent_r;
  logic [1:0]      act_r;
  logic            rec_r;
  logic            gave_r;
  logic            we_r;
  logic            bump_r;
  logic [SH_W-1:0] sh_r;

  logic            out_valid_r;
  logic            out_valid_nxt;
  logic [1:0]      out_act_r;
  logic            out_rec_r;
  logic            out_gave_r;
  logic [7:0]      out_used_r;
  logic            load;

  spr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_SLAVES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (job_r.slave),
    .wdata (wr_ent),
    .re    (ram_re),
    .raddr (job.slave),
    .rdata (ram_rdata)
  );

  assign ent = valid_r[job_r.slave] ? entry_t'(ram_rdata) : '0;

  always_comb begin
    ev_ent  = ent;
    ev_act  = ACT_NONE;
    ev_rec  = 1'b0;
    ev_gave = 1'b0;
    ev_we   = 1'b0;
    ev_bump = 1'b0;
    ev_sh   = (ent.attempts > 8'(SHIFT_CAP)) ? SHIFT_CAP : ent.attempts[SH_W-1:0];
    if (job_r.in_range) begin
      if (job_r.clear_entry) begin
        ev_we           = 1'b1;
        ev_ent.attempts = '0;
        ev_ent.failed   = 1'b0;
        ev_ent.next_try = '0;
      end else if (job_r.reach) begin
        ev_we = 1'b1;
        if (job_r.healthy) begin
          ev_rec = ent.unhealthy;
          ev_ent = '0;
        end else begin
          ev_ent.unhealthy = 1'b1;
          if (!ent.failed) begin
            if (job_r.cand_act == ACT_OP) begin
              ev_act = ACT_OP;
            end else if (job_r.cand_act == ACT_ACK || job_r.cand_act == ACT_RECFG) begin
              if (job_r.now_ns < ent.next_try) begin
                ev_act = ACT_NONE;
              end else if (ent.attempts >= cfg.attempt_limit) begin
                ev_ent.failed = 1'b1;
                ev_gave       = 1'b1;
              end else begin
                ev_act          = job_r.cand_act;
                ev_ent.attempts = ent.attempts + 8'd1;
                ev_bump         = 1'b1;
              end
            end
          end
        end
      end
    end
  end

  always_comb begin
    wr_ent = new_ent_r;
    if (bump_r) begin
      wr_ent.next_try = job_r.now_ns + ({32'd0, cfg.backoff_base} << sh_r);
    end
  end

  assign load = (state_r == S_UPD) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt     = state_r;
    job_pop       = 1'b0;
    ram_re        = 1'b0;
    ram_we        = 1'b0;
    valid_nxt     = valid_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (job_valid) begin
          job_pop   = 1'b1;
          ram_re    = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (load) begin
          ram_we        = we_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (we_r) begin
            valid_nxt[job_r.slave] = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      job_r <= job;
    end
    if (state_r == S_EVAL) begin
      new_ent_r <= ev_ent;
      act_r     <= ev_act;
      rec_r     <= ev_rec;
      gave_r    <= ev_gave;
      we_r      <= ev_we;
      bump_r    <= ev_bump;
      sh_r      <= ev_sh;
    end
    if (load) begin
      out_act_r  <= act_r;
      out_rec_r  <= rec_r;
      out_gave_r <= gave_r;
      out_used_r <= job_r.in_range ? new_ent_r.attempts : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.action        = out_act_r;
  assign out_ch.recovered     = out_rec_r;
  assign out_ch.gave_up       = out_gave_r;
  assign out_ch.attempts_used = out_used_r;

`ifndef ASSERT_OFF
  a_eval_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EVAL |-> $past(state_r == S_IDLE && job_valid))
    else $error("Evaluation entered without a table read.");
`endif
`ifndef ASSERT_OFF
  a_gave_up_no_action: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_gave_r |-> out_act_r == ACT_NONE)
    else $error("Give-up reported together with an action.");
`endif
`ifndef ASSERT_OFF
  a_recovered_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_rec_r |-> out_act_r == ACT_NONE && out_used_r == 8'd0)
    else $error("Recovered slave reported with action or attempts.");
`endif
`ifndef ASSERT_OFF
  a_write_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> out_valid_r && state_r == S_IDLE)
    else $error("Table write without a loaded result.");
`endif

endmodule
